[hw/rtl/orld_pkg.sv]
// Shared types and constants for the output-restricted linear deque.
// No dependencies; imported by orld_ram users, orld_ctrl and the top level.
`timescale 1ns / 1ps

package orld_pkg;

    // Store geometry
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int DATA_W = 32;

    // Commands
    typedef enum logic [1:0] {
        CMD_INS_REAR  = 2'd0,
        CMD_INS_FRONT = 2'd1,
        CMD_DEL_FRONT = 2'd2,
        CMD_DISPLAY   = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL_REAR  = 2'd1,
        ST_FULL_FRONT = 2'd2,
        ST_EMPTY      = 2'd3
    } status_t;

    // One result item
    typedef struct packed {
        status_t            status;
        logic signed [31:0] element;
        logic               last;
    } res_t;

    // Memory access request from the controller
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
    } ram_req_t;

endpackage

[hw/rtl/orld_ram.sv]
// Generic single-write, single-read synchronous RAM, registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module orld_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/orld_ctrl.sv]
// Deque controller: front/rear indices, command sequencing and store access.
// Depends on orld_pkg; drives the slot RAM and feeds the output register.
`timescale 1ns / 1ps

module orld_ctrl
    import orld_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  logic signed [31:0]  value,
    output logic                res_valid,
    output res_t                res,
    input  logic                res_ready,
    output ram_req_t            ram_req,
    input  logic [DATA_W-1:0]   rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEL,
        S_WALK
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic             empty_reg, empty_next;
    logic             accept;
    logic             walk_last;

    // Take a new item only when idle and the result slot is free
    assign in_stall  = (state_reg != S_IDLE) || !res_ready;
    assign accept    = in_valid && !in_stall;
    assign walk_last = (ptr_reg == tail_reg);

    // Next state, store access and result
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        ptr_next   = ptr_reg;
        empty_next = empty_reg;
        res_valid  = 1'b0;
        res        = '{status: ST_OK, element: '0, last: 1'b1};
        ram_req    = '{wr_en: 1'b0, wr_addr: '0, wr_data: value,
                       rd_en: 1'b0, rd_addr: head_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_t'(cmd))
                        CMD_INS_REAR:
                        begin
                            res_valid = 1'b1;
                            if (empty_reg)
                            begin
                                head_next     = '0;
                                tail_next     = '0;
                                empty_next    = 1'b0;
                                ram_req.wr_en = 1'b1;
                            end
                            else if (tail_reg == LAST_IDX)
                            begin
                                res.status = ST_FULL_REAR;
                            end
                            else
                            begin
                                tail_next       = tail_reg + 1'b1;
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = tail_reg + 1'b1;
                            end
                        end
                        CMD_INS_FRONT:
                        begin
                            res_valid = 1'b1;
                            if (empty_reg)
                            begin
                                head_next     = '0;
                                tail_next     = '0;
                                empty_next    = 1'b0;
                                ram_req.wr_en = 1'b1;
                            end
                            else if (head_reg == '0)
                            begin
                                res.status = ST_FULL_FRONT;
                            end
                            else
                            begin
                                head_next       = head_reg - 1'b1;
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = head_reg - 1'b1;
                            end
                        end
                        CMD_DEL_FRONT:
                        begin
                            if (empty_reg)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                ram_req.rd_en = 1'b1;
                                state_next    = S_DEL;
                            end
                        end
                        CMD_DISPLAY:
                        begin
                            if (empty_reg)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                ram_req.rd_en = 1'b1;
                                ptr_next      = head_reg;
                                state_next    = S_WALK;
                            end
                        end
                    endcase
                end
            end

            // Hand out the front element, then drop it
            S_DEL:
            begin
                res_valid   = 1'b1;
                res.element = rd_data;
                if (res_ready)
                begin
                    if (head_reg >= tail_reg)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b1;
                    end
                    else
                    begin
                        head_next = head_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            // Walk front to rear, one slot per accepted result
            S_WALK:
            begin
                res_valid   = 1'b1;
                res.element = rd_data;
                res.last    = walk_last;
                if (res_ready)
                begin
                    if (walk_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next        = ptr_reg + 1'b1;
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = ptr_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and indices
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            ptr_reg   <= '0;
            empty_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            ptr_reg   <= ptr_next;
            empty_reg <= empty_next;
        end
    end

    // An empty deque parks both indices at slot 0
    a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (head_reg == '0) && (tail_reg == '0))
        else $error("empty deque with nonzero index");

    // Front never passes rear
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("head index beyond tail index");

    // The walk pointer stays inside the occupied range
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (ptr_reg >= head_reg) && (ptr_reg <= tail_reg))
        else $error("display pointer out of range");

    // A pending read result holds while the output side is full
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) && !res_ready |=> $stable(res) && res_valid)
        else $error("pending result changed while stalled");

    // Busy work never coexists with a new item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("item accepted while busy");

endmodule

[hw/rtl/output_restricted_linear_deque_core.sv]
// An insert answers in the cycle after acceptance. A delete result passes
// through the RAM read register, then the output register; a display sends
// its first result the same way, then one result per cycle unless stalled.
// One insert per cycle is taken unless the output stalls; no new command is
// taken while a delete or display is busy. Reset clears indices, empty flag
// and output valid; the slot store is not cleared.
`timescale 1ns / 1ps

module output_restricted_linear_deque_core
    import orld_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] element,
    output logic               last
);

    ram_req_t          ram_req;
    logic [DATA_W-1:0] rd_data;
    logic              res_valid;
    res_t              res;
    logic              res_ready;
    logic              out_valid_reg;
    res_t              out_reg;

    orld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .value     (value),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .ram_req   (ram_req),
        .rd_data   (rd_data)
    );

    orld_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (rd_data)
    );

    // Output register frees as soon as the downstream side takes its item
    assign res_ready = !out_valid_reg || !out_stall;

    // Hold the output item valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    // Load the output payload
    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_reg.status;
    assign element   = out_reg.element;
    assign last      = out_reg.last;

endmodule
